// File: src/dual_series_arithmetic_defines.svh
// Assertion macros for the dual series arithmetic block.
// Each macro checks a property on the rising edge of the given clock and
// is switched off while the given active-low reset is asserted.
`ifndef DUAL_SERIES_ARITHMETIC_DEFINES_SVH
`define DUAL_SERIES_ARITHMETIC_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dual series arithmetic: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dual series arithmetic: next-cycle check failed");

`else

`define DSA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/dsa_pkg.sv
package dsa_pkg;

  localparam int DATA_W           = 32;
  localparam int FRAC_W           = 16;
  localparam int NCOEF            = 5;
  localparam int PROD_W           = 2 * DATA_W - FRAC_W;
  // Up to five terms are summed in one lane, so three guard bits suffice.
  localparam int SUM_W            = PROD_W + 3;
  localparam int SERIES_TERMS_DEF = 4;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    FUNC_MUL      = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_SCALE    = 2'd2,
    FUNC_ADD_REAL = 2'd3
  } func_t;

  // Load enables for the two lane pipeline registers.
  typedef struct packed {
    logic ld_term;
    logic ld_res;
  } lane_ctrl_t;

endpackage

// File: src/dual_series_arithmetic.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   in_func, in_a_*, in_b_* (Q16.16)
// out_      output     out_valid / out_stall out_r_*, out_overflow
//
// With out_stall low, one word enters and one result word leaves per clock.
// A word passes three registers: lane terms (products or operands), lane sums
// with saturation, then the merged output register that drives out_valid.
// Reset (rst_n low at a clock edge) clears the three stage valid bits only.
// out_stall backs up through the stages: a stage is refilled whenever it is
// empty or its word moves on, so in_stall rises only when all three are full.
`include "dual_series_arithmetic_defines.svh"

module dual_series_arithmetic
  import dsa_pkg::*;
#(
  parameter int SERIES_TERMS = SERIES_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  data_t       in_a_real,
  input  data_t       in_a_coef1,
  input  data_t       in_a_coef2,
  input  data_t       in_a_coef3,
  input  data_t       in_a_coef4,
  input  data_t       in_b_real,
  input  data_t       in_b_coef1,
  input  data_t       in_b_coef2,
  input  data_t       in_b_coef3,
  input  data_t       in_b_coef4,

  output logic        out_valid,
  input  logic        out_stall,
  output data_t       out_r_real,
  output data_t       out_r_coef1,
  output data_t       out_r_coef2,
  output data_t       out_r_coef3,
  output data_t       out_r_coef4,
  output logic        out_overflow
);

  data_t      a        [NCOEF];
  data_t      b        [NCOEF];
  data_t      lane_res [NCOEF];
  logic       lane_ovf [NCOEF];
  data_t      r        [NCOEF];
  func_t      func;
  lane_ctrl_t lane_ctrl;

  logic s1_v_r;
  logic s2_v_r;
  logic out_v_r;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic ld_out;
  logic ovf_pinned;

  assign a[0] = in_a_real;
  assign a[1] = in_a_coef1;
  assign a[2] = in_a_coef2;
  assign a[3] = in_a_coef3;
  assign a[4] = in_a_coef4;
  assign b[0] = in_b_real;
  assign b[1] = in_b_coef1;
  assign b[2] = in_b_coef2;
  assign b[3] = in_b_coef3;
  assign b[4] = in_b_coef4;
  assign func = func_t'(in_func);

  // Each stage may take a new word when it is empty or its word leaves.
  assign s3_ready = !out_v_r || !out_stall;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;

  assign in_stall          = !s1_ready;
  assign lane_ctrl.ld_term = in_valid && s1_ready;
  assign lane_ctrl.ld_res  = s1_v_r && s2_ready;
  assign ld_out            = s2_v_r && s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // One lane per result coefficient; lanes beyond the series length are
  // not built and their coefficients read as zero without overflow.
  for (genvar k = 0; k < NCOEF; k++) begin : g_lane
    if (k <= SERIES_TERMS) begin : g_on
      dsa_lane #(
        .LANE_IDX (k)
      ) u_lane (
        .clk  (clk),
        .ctrl (lane_ctrl),
        .func (func),
        .a    (a),
        .b    (b),
        .res  (lane_res[k]),
        .ovf  (lane_ovf[k])
      );
    end else begin : g_off
      assign lane_res[k] = '0;
      assign lane_ovf[k] = 1'b0;
    end
  end

  dsa_merge u_merge (
    .clk      (clk),
    .ld       (ld_out),
    .lane_res (lane_res),
    .lane_ovf (lane_ovf),
    .r        (r),
    .overflow (out_overflow)
  );

  assign out_valid   = out_v_r;
  assign out_r_real  = r[0];
  assign out_r_coef1 = r[1];
  assign out_r_coef2 = r[2];
  assign out_r_coef3 = r[3];
  assign out_r_coef4 = r[4];

  // High when any output field sits at the top or the bottom of its range.
  always_comb begin
    ovf_pinned = 1'b0;
    for (int k = 0; k < NCOEF; k++) begin
      ovf_pinned = ovf_pinned || (r[k] == {1'b0, {(DATA_W-1){1'b1}}})
                              || (r[k] == {1'b1, {(DATA_W-1){1'b0}}});
    end
  end

  // Input is held off only when every stage is occupied.
  `DSA_ASSERT_SAME(a_stall_needs_full, clk, rst_n, in_stall, s1_v_r && s2_v_r && out_v_r)

  // A product word that cannot move on stays in its stage.
  `DSA_ASSERT_NEXT(a_s1_kept, clk, rst_n, s1_v_r && !s2_ready, s1_v_r)

  // A flagged result carries at least one field pinned at a range limit.
  `DSA_ASSERT_SAME(a_ovf_at_limit, clk, rst_n, out_v_r && out_overflow, ovf_pinned)

endmodule

// File: src/dsa_lane.sv
module dsa_lane
  import dsa_pkg::*;
#(
  parameter int LANE_IDX = 0
) (
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  func_t      func,
  input  data_t      a [NCOEF],
  input  data_t      b [NCOEF],
  output data_t      res,
  output logic       ovf
);

  localparam int NPROD = LANE_IDX + 1;
  localparam int NSLOT = (NPROD < 2) ? 2 : NPROD;

  prod_t term_nxt [NSLOT];
  prod_t term_r   [NSLOT];
  prod_t prod_fl  [NPROD];
  sum_t  sum;
  data_t res_nxt;
  data_t res_r;
  logic  ovf_nxt;
  logic  ovf_r;

  // One multiplier per product of this coefficient. The first one also
  // serves the scale operation, where it forms a_k * b_real.
  for (genvar p = 0; p < NPROD; p++) begin : g_mul
    data_t                     mul_x;
    data_t                     mul_y;
    logic signed [2*DATA_W-1:0] mul_full;
    if (p == 0) begin : g_first
      assign mul_x = (func == FUNC_SCALE) ? a[LANE_IDX] : a[0];
      assign mul_y = (func == FUNC_SCALE) ? b[0] : b[LANE_IDX];
    end else begin : g_rest
      assign mul_x = a[p];
      assign mul_y = b[LANE_IDX-p];
    end
    assign mul_full   = mul_x * mul_y;
    // Dropping the low fraction bits of a signed product rounds to minus infinity.
    assign prod_fl[p] = mul_full[2*DATA_W-1:FRAC_W];
  end

  always_comb begin
    for (int s = 0; s < NSLOT; s++) begin
      term_nxt[s] = '0;
    end
    unique case (func)
      FUNC_MUL: begin
        for (int p = 0; p < NPROD; p++) begin
          term_nxt[p] = prod_fl[p];
        end
      end
      FUNC_ADD: begin
        term_nxt[0] = {{(PROD_W-DATA_W){a[LANE_IDX][DATA_W-1]}}, a[LANE_IDX]};
        term_nxt[1] = {{(PROD_W-DATA_W){b[LANE_IDX][DATA_W-1]}}, b[LANE_IDX]};
      end
      FUNC_SCALE: begin
        term_nxt[0] = prod_fl[0];
      end
      FUNC_ADD_REAL: begin
        term_nxt[0] = {{(PROD_W-DATA_W){a[LANE_IDX][DATA_W-1]}}, a[LANE_IDX]};
        if (LANE_IDX == 0) begin
          term_nxt[1] = {{(PROD_W-DATA_W){b[0][DATA_W-1]}}, b[0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_term) begin
      term_r <= term_nxt;
    end
  end

  always_comb begin
    sum = '0;
    for (int s = 0; s < NSLOT; s++) begin
      sum = sum + {{(SUM_W-PROD_W){term_r[s][PROD_W-1]}}, term_r[s]};
    end
    // The sum fits when every bit from the result sign upward agrees.
    if ((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1])) begin
      res_nxt = sum[DATA_W-1:0];
      ovf_nxt = 1'b0;
    end else begin
      res_nxt = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_res) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

// File: src/dsa_merge.sv
module dsa_merge
  import dsa_pkg::*;
(
  input  logic  clk,
  input  logic  ld,
  input  data_t lane_res [NCOEF],
  input  logic  lane_ovf [NCOEF],
  output data_t r        [NCOEF],
  output logic  overflow
);

  data_t r_r [NCOEF];
  logic  overflow_r;
  logic  overflow_nxt;

  always_comb begin
    overflow_nxt = 1'b0;
    for (int k = 0; k < NCOEF; k++) begin
      overflow_nxt = overflow_nxt | lane_ovf[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      r_r        <= lane_res;
      overflow_r <= overflow_nxt;
    end
  end

  assign r        = r_r;
  assign overflow = overflow_r;

endmodule
